// File: sv/load_stepped_frequency_governor_top_assert.svh
// Assertion macros shared by the checker of the frequency governor.
// Each macro expands to one clocked concurrent assertion on clk, disabled in rst.
`ifndef LOAD_STEPPED_FREQUENCY_GOVERNOR_TOP_ASSERT_SVH
`define LOAD_STEPPED_FREQUENCY_GOVERNOR_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LSFG_ASSERT_SAME(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LSFG_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

// File: sv/lsfg_pkg.sv
// Shared types and constants of the load-stepped frequency governor.
// Used by the top level, the load divider and the port checker.
package lsfg_pkg;

  localparam int unsigned CNT_W     = 5;   // bit position counter of the serial pass
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FREQ_W    = 22;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned DIV_STEPS = 7;   // quotient bits of the load divider

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_NOTICE = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [2:0] REG_UP_THR   = 3'd0;
  localparam logic [2:0] REG_DOWN_THR = 3'd1;
  localparam logic [2:0] REG_STEP_PCT = 3'd2;
  localparam logic [2:0] REG_IGN_NICE = 3'd3;
  localparam logic [2:0] REG_MIN_FREQ = 3'd4;
  localparam logic [2:0] REG_MAX_FREQ = 3'd5;

  localparam logic [PCT_W-1:0]  RST_UP_THR   = 7'd80;
  localparam logic [PCT_W-1:0]  RST_DOWN_THR = 7'd40;
  localparam logic [PCT_W-1:0]  RST_STEP_PCT = 7'd10;
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ = 22'd728000;
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ = 22'd2600000;

  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0]  DOWN_MARGIN  = 7'd10;
  localparam logic [FREQ_W-1:0] STEP_MIN_KHZ = 22'd5;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] busy;
    logic [WORD_W-1:0] dwall;
  } lsfg_div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } lsfg_div_res_t;

endpackage

// File: sv/lsfg_load_div.sv
// Restoring divider for the load percentage: floor(100 * busy / wall), one bit a cycle.
// Depends on lsfg_pkg for the request and result structs.
module lsfg_load_div
  import lsfg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  lsfg_div_req_t req,
  output lsfg_div_res_t res
);

  logic                rn;
  logic                done;
  logic [2:0]          cnt;
  logic [38:0]         rem;
  logic [38:0]         dsh;
  logic [PCT_W-1:0]    q;
  logic [38:0]         num;
  logic                ge;

  // 100 * busy as 64 + 32 + 4 times busy.
  assign num = {1'b0, req.busy, 6'b0} + {2'b0, req.busy, 5'b0} + {5'b0, req.busy, 2'b0};
  assign ge  = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      rn   <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rn  <= 1'b1;
        cnt <= 3'(DIV_STEPS - 1);
      end else if (rn) begin
        if (cnt == 3'd0) begin
          rn   <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 3'd1;
        end
      end
    end
  end

  // The quotient stays within 100 while busy does not exceed wall, so the divisor starts shifted up by six.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= num;
      dsh <= {1'b0, req.dwall, 6'b0};
    end else if (rn) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[PCT_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  assign res.done = done;
  assign res.quot = q;

endmodule

// File: sv/load_stepped_frequency_governor_top.sv
// Channel   Dir  Transfer when          Contents
// s_*       in   s_tvalid & s_tready    opcode (tuser); wall/idle/nice counters, current frequency
// m_*       out  m_tvalid & m_tready    request flag (tuser); target frequency, load percent
// APB       in   psel&penable&pwrite    six governor registers at 4-byte spacing
// A load sample goes from its transfer to its result through a bit-serial pass over the counter
// deltas (which also divides the frequency step by 100), a state that starts the divider, a wait
// for the divider's seven quotient bits, then the decision, which waits while the output is held.
// Notices, starts and unused opcodes skip the pass and the divider and go straight to the decision.
// One item is in work at a time; a finished result waits in the output register.
// Reset is synchronous; registers return to their defaults and the request to zero.
module load_stepped_frequency_governor_top
  import lsfg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] opcode
  input  logic [1:0]   s_tuser,
  // [31:0] wall_us, [63:32] idle_us, [95:64] nice_us, [117:96] cur_freq_khz, [119:118] zero
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] request_valid
  output logic         m_tuser,
  // [21:0] target_freq_khz, [28:22] load_percent, [31:29] zero
  output logic [31:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SER   = 3'd1;
  localparam logic [2:0] ST_DIVGO = 3'd2;
  localparam logic [2:0] ST_DIVW  = 3'd3;
  localparam logic [2:0] ST_DEC   = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [PCT_W-1:0]  up_thr, down_thr, step_pct;
  logic              ign_nice;
  logic [FREQ_W-1:0] min_f, max_f;
  logic [2:0]        reg_idx;

  // Governor state.
  logic [WORD_W-1:0] pw, pi, pn;
  logic [FREQ_W-1:0] req_f, req_f_next;

  // Item in work.
  logic [1:0]        op;
  logic [FREQ_W-1:0] cur;
  logic [WORD_W-1:0] w_sh, i_sh, n_sh;
  logic [WORD_W-1:0] dwall_sh, busy_sh;
  logic              bw, bi, bn, cs, bb, nz;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] prod;
  logic [PCT_W-1:0]  srem;
  logic [FREQ_W-1:0] sq;

  logic              in_xfer, fire;
  logic [1:0]        in_op;
  logic [PCT_W-1:0]  pct_c;
  logic [28:0]       prod_w;

  // Serial bit signals.
  logic dw, di, dn, dn_e, dt, bu;
  logic bw_n, bi_n, bn_n, cs_n, bb_n;
  logic [7:0]        st_t;
  logic              st_bit;

  // Decision.
  lsfg_div_req_t     div_req;
  lsfg_div_res_t     div_res;
  logic [PCT_W-1:0]  load_v;
  logic [FREQ_W-1:0] step_up, up_r, dn_r0, dn_r;
  logic [FREQ_W:0]   up_sum;
  logic              down_ok, valid_v;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign pct_c    = (step_pct > PCT_FULL) ? PCT_FULL : step_pct;
  assign prod_w   = 29'(pct_c) * 29'(max_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      up_thr   <= RST_UP_THR;
      down_thr <= RST_DOWN_THR;
      step_pct <= RST_STEP_PCT;
      ign_nice <= 1'b0;
      min_f    <= RST_MIN_FREQ;
      max_f    <= RST_MAX_FREQ;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_UP_THR:   up_thr   <= pwdata[PCT_W-1:0];
        REG_DOWN_THR: down_thr <= pwdata[PCT_W-1:0];
        REG_STEP_PCT: step_pct <= pwdata[PCT_W-1:0];
        REG_IGN_NICE: ign_nice <= pwdata[0];
        REG_MIN_FREQ: min_f    <= pwdata[FREQ_W-1:0];
        REG_MAX_FREQ: max_f    <= pwdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UP_THR:   prdata = {25'b0, up_thr};
      REG_DOWN_THR: prdata = {25'b0, down_thr};
      REG_STEP_PCT: prdata = {25'b0, step_pct};
      REG_IGN_NICE: prdata = {31'b0, ign_nice};
      REG_MIN_FREQ: prdata = {10'b0, min_f};
      REG_MAX_FREQ: prdata = {10'b0, max_f};
      default:      prdata = '0;
    endcase
  end

  // One bit of every delta per cycle, LSB first: wall, idle, nice, idle + nice, busy.
  always_comb begin
    dw   = w_sh[0] ^ pw[0] ^ bw;
    bw_n = (~w_sh[0] & pw[0]) | (~(w_sh[0] ^ pw[0]) & bw);
    di   = i_sh[0] ^ pi[0] ^ bi;
    bi_n = (~i_sh[0] & pi[0]) | (~(i_sh[0] ^ pi[0]) & bi);
    dn   = n_sh[0] ^ pn[0] ^ bn;
    bn_n = (~n_sh[0] & pn[0]) | (~(n_sh[0] ^ pn[0]) & bn);
    dn_e = ign_nice & dn;
    dt   = di ^ dn_e ^ cs;
    cs_n = (di & dn_e) | (cs & (di ^ dn_e));
    bu   = dw ^ dt ^ bb;
    bb_n = (~dw & dt) | (~(dw ^ dt) & bb);
    // Frequency step: the product is divided by 100 one bit per cycle, MSB first.
    st_t   = {srem, prod[WORD_W-1]};
    st_bit = st_t >= {1'b0, PCT_FULL};
  end

  assign div_req.start = (state == ST_DIVGO);
  assign div_req.busy  = busy_sh;
  assign div_req.dwall = dwall_sh;

  lsfg_load_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_comb begin
    load_v   = (op == OP_SAMPLE && nz && !bb) ? div_res.quot : '0;
    step_up  = (sq == '0) ? STEP_MIN_KHZ : sq;
    up_sum   = {1'b0, req_f} + {1'b0, step_up};
    up_r     = (up_sum > {1'b0, max_f}) ? max_f : up_sum[FREQ_W-1:0];
    dn_r0    = (req_f > sq) ? req_f - sq : '0;
    dn_r     = (dn_r0 < min_f) ? min_f : dn_r0;
    down_ok  = (down_thr > DOWN_MARGIN) && (load_v < down_thr - DOWN_MARGIN);
    req_f_next = req_f;
    valid_v  = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (step_pct != '0) begin
          if (load_v > up_thr) begin
            if (req_f != max_f) begin
              req_f_next = up_r;
              valid_v    = 1'b1;
            end
          end else if (down_ok) begin
            req_f_next = dn_r;
            valid_v    = (cur != min_f);
          end
        end
      end
      OP_NOTICE: begin
        if (req_f > max_f || req_f < min_f) begin
          req_f_next = cur;
        end
      end
      OP_START: begin
        req_f_next = cur;
      end
      default: ;
    endcase
  end

  assign fire = (state == ST_DEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      req_f    <= '0;
      pw       <= '0;
      pi       <= '0;
      pn       <= '0;
      cnt      <= '0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt <= '0;
            if (in_op == OP_SAMPLE) begin
              state <= ST_SER;
            end else begin
              state <= ST_DEC;
              if (in_op == OP_START) begin
                pw <= s_tdata[31:0];
                pi <= s_tdata[63:32];
                if (ign_nice) begin
                  pn <= s_tdata[95:64];
                end
              end
            end
          end
        end
        ST_SER: begin
          // Rotating the stored counters leaves them holding this sample at the end of the pass.
          pw  <= {w_sh[0], pw[WORD_W-1:1]};
          pi  <= {i_sh[0], pi[WORD_W-1:1]};
          pn  <= {ign_nice ? n_sh[0] : pn[0], pn[WORD_W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= ST_DIVGO;
          end
        end
        ST_DIVGO: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_res.done) begin
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (fire) begin
            req_f <= req_f_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op   <= in_op;
      cur  <= s_tdata[117:96];
      w_sh <= s_tdata[31:0];
      i_sh <= s_tdata[63:32];
      n_sh <= s_tdata[95:64];
      bw   <= 1'b0;
      bi   <= 1'b0;
      bn   <= 1'b0;
      cs   <= 1'b0;
      bb   <= 1'b0;
      nz   <= 1'b0;
      prod <= {3'b0, prod_w};
      srem <= '0;
    end else if (state == ST_SER) begin
      w_sh     <= w_sh >> 1;
      i_sh     <= i_sh >> 1;
      n_sh     <= n_sh >> 1;
      bw       <= bw_n;
      bi       <= bi_n;
      bn       <= bn_n;
      cs       <= cs_n;
      bb       <= bb_n;
      nz       <= nz | dw;
      dwall_sh <= {dw, dwall_sh[WORD_W-1:1]};
      busy_sh  <= {bu, busy_sh[WORD_W-1:1]};
      prod     <= {prod[WORD_W-2:0], 1'b0};
      srem     <= st_bit ? 7'(st_t - {1'b0, PCT_FULL}) : st_t[PCT_W-1:0];
      sq       <= {sq[FREQ_W-2:0], st_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= valid_v;
      m_tdata <= {3'b0, load_v, req_f_next};
    end
  end

endmodule

// File: sv/lsfg_checker.sv
// Port-level checker for the frequency governor, bound to the top level.
// Depends on lsfg_pkg and the assertion macros header.
`include "load_stepped_frequency_governor_top_assert.svh"

module lsfg_checker
  import lsfg_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic         m_tuser,
  input logic [31:0]  m_tdata
);

  // Only one item is in work, so ready must drop right after an input transfer.
  `LSFG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `LSFG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped before transfer")
  `LSFG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable({m_tuser, m_tdata}), "stalled result changed")
  `LSFG_ASSERT_SAME(a_load_range, m_tvalid, m_tdata[28:22] <= PCT_FULL, "load above one hundred")

endmodule

bind load_stepped_frequency_governor_top lsfg_checker u_lsfg_checker (.*);

// File: tb/governor_checker.sv
// Checker for the load-stepped frequency governor. It follows the register port and both
// stream channels, predicts each result when an item transfers and compares it on output.
// Depends on lsfg_pkg for field widths, opcodes, register indexes and reset values.
module governor_checker
  import lsfg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // [1:0] opcode
  input  logic [1:0]   s_tuser,
  // [31:0] wall_us, [63:32] idle_us, [95:64] nice_us, [117:96] cur_freq_khz, [119:118] zero
  input  logic [119:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // [0] request_valid
  input  logic         m_tuser,
  // [21:0] target_freq_khz, [28:22] load_percent, [31:29] zero
  input  logic [31:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FREQ_W-1:0] cur_freq;
    logic [WORD_W-1:0] nice;
    logic [WORD_W-1:0] idle;
    logic [WORD_W-1:0] wall;
    logic [1:0]        opcode;
  } governor_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]  load;
    logic [FREQ_W-1:0] target;
    logic              request;
  } governor_result_t;

  logic [PCT_W-1:0]  up_thr;
  logic [PCT_W-1:0]  down_thr;
  logic [PCT_W-1:0]  step_pct;
  logic              nice_as_idle;
  logic [FREQ_W-1:0] lower_khz;
  logic [FREQ_W-1:0] upper_khz;

  logic [WORD_W-1:0] last_wall;
  logic [WORD_W-1:0] last_idle;
  logic [WORD_W-1:0] last_nice;
  logic [FREQ_W-1:0] tracked_khz;

  governor_result_t  expected_requests[$];

  function automatic governor_result_t next_request(governor_item_t item);
    governor_result_t  res;
    logic [WORD_W-1:0] dwall;
    logic [WORD_W-1:0] didle;
    logic [WORD_W-1:0] step_khz;
    logic [WORD_W-1:0] freq;
    logic [63:0]       ratio;
    logic [PCT_W-1:0]  pct;
    res = '0;
    case (item.opcode)
      OP_SAMPLE: begin
        dwall = item.wall - last_wall;
        didle = item.idle - last_idle;
        last_wall = item.wall;
        last_idle = item.idle;
        if (nice_as_idle) begin
          didle = didle + (item.nice - last_nice);
          last_nice = item.nice;
        end
        // A zero wall delta, or more idle than wall time, reads as no load at all.
        if (dwall != 0 && dwall >= didle) begin
          ratio = {32'd0, dwall - didle};
          ratio = ratio * PCT_FULL / {32'd0, dwall};
          res.load = ratio[PCT_W-1:0];
        end
        if (step_pct != 0) begin
          pct = (step_pct > PCT_FULL) ? PCT_FULL : step_pct;
          ratio = {57'd0, pct} * {42'd0, upper_khz} / PCT_FULL;
          step_khz = ratio[WORD_W-1:0];
          if (res.load > up_thr) begin
            if (tracked_khz != upper_khz) begin
              if (step_khz == 0) begin
                step_khz = {10'd0, STEP_MIN_KHZ};
              end
              freq = {10'd0, tracked_khz} + step_khz;
              if (freq > {10'd0, upper_khz}) begin
                freq = {10'd0, upper_khz};
              end
              tracked_khz = freq[FREQ_W-1:0];
              res.request = 1'b1;
            end
          end else if (down_thr > DOWN_MARGIN && res.load < down_thr - DOWN_MARGIN) begin
            // The step down stops at zero first, then at the lower bound.
            freq = ({10'd0, tracked_khz} > step_khz) ? {10'd0, tracked_khz} - step_khz : '0;
            if (freq < {10'd0, lower_khz}) begin
              freq = {10'd0, lower_khz};
            end
            tracked_khz = freq[FREQ_W-1:0];
            res.request = (item.cur_freq != lower_khz);
          end
        end
      end
      OP_NOTICE: begin
        if (tracked_khz > upper_khz || tracked_khz < lower_khz) begin
          tracked_khz = item.cur_freq;
        end
      end
      OP_START: begin
        tracked_khz = item.cur_freq;
        last_wall = item.wall;
        last_idle = item.idle;
        if (nice_as_idle) begin
          last_nice = item.nice;
        end
      end
      default: ;
    endcase
    res.target = tracked_khz;
    return res;
  endfunction

  always @(posedge clk) begin
    governor_result_t got;
    governor_result_t want;
    if (rst) begin
      up_thr = RST_UP_THR;
      down_thr = RST_DOWN_THR;
      step_pct = RST_STEP_PCT;
      nice_as_idle = 1'b0;
      lower_khz = RST_MIN_FREQ;
      upper_khz = RST_MAX_FREQ;
      last_wall = '0;
      last_idle = '0;
      last_nice = '0;
      tracked_khz = '0;
      expected_requests.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_UP_THR:   up_thr = pwdata[PCT_W-1:0];
          REG_DOWN_THR: down_thr = pwdata[PCT_W-1:0];
          REG_STEP_PCT: step_pct = pwdata[PCT_W-1:0];
          REG_IGN_NICE: nice_as_idle = pwdata[0];
          REG_MIN_FREQ: lower_khz = pwdata[FREQ_W-1:0];
          REG_MAX_FREQ: upper_khz = pwdata[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[28:0], m_tuser};
        if (expected_requests.size() == 0) begin
          $error("result transfer 0x%h with no item waiting for it", m_tdata);
          mismatches++;
        end else begin
          want = expected_requests.pop_front();
          if (got.request !== want.request) begin
            $error("request_valid: expected %0d, actual %0d", want.request, got.request);
            mismatches++;
          end
          if (got.target !== want.target) begin
            $error("target_freq_khz: expected %0d, actual %0d", want.target, got.target);
            mismatches++;
          end
          if (got.load !== want.load) begin
            $error("load_percent: expected %0d, actual %0d", want.load, got.load);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_requests.push_back(next_request({s_tdata[117:0], s_tuser}));
      end
    end
    pending = expected_requests.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top for the load-stepped frequency governor: clock, reset, register setup,
// directed and random item traffic with random idling on both channels, and the verdict.
// Depends on lsfg_pkg, load_stepped_frequency_governor_top and governor_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsfg_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         PHASES          = 12;
  localparam int         PHASE_ITEMS     = 124;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES    = 60;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [1:0] opcode
  logic [1:0]   s_tuser = '0;
  // [31:0] wall_us, [63:32] idle_us, [95:64] nice_us, [117:96] cur_freq_khz, [119:118] zero
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [0] request_valid
  logic         m_tuser;
  // [21:0] target_freq_khz, [28:22] load_percent, [31:29] zero
  logic [31:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int           mismatches;
  int           pending;

  logic [WORD_W-1:0] cnt_wall = '0;
  logic [WORD_W-1:0] cnt_idle = '0;
  logic [WORD_W-1:0] cnt_nice = '0;
  logic [FREQ_W-1:0] cfg_min = RST_MIN_FREQ;
  logic [FREQ_W-1:0] cfg_max = RST_MAX_FREQ;
  bit                no_idling = 1'b0;
  bit                long_stall = 1'b0;
  int unsigned       send_gap_pct = 20;
  int unsigned       sink_gap_pct = 8;

  load_stepped_frequency_governor_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  governor_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : sink
    bit held;
    held = 1'b0;
    forever begin
      if (long_stall && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (!no_idling && $urandom_range(0, 99) < sink_gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Called right after a rising edge; returns at the edge where the transfer happens.
  task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] wall,
                           input logic [WORD_W-1:0] idle, input logic [WORD_W-1:0] nice,
                           input logic [FREQ_W-1:0] cur);
    if (!no_idling && $urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, cur, nice, idle, wall};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_sample(input logic [WORD_W-1:0] dwall, input logic [WORD_W-1:0] didle,
                             input logic [WORD_W-1:0] dnice, input logic [FREQ_W-1:0] cur);
    cnt_wall = cnt_wall + dwall;
    cnt_idle = cnt_idle + didle;
    cnt_nice = cnt_nice + dnice;
    send_item(OP_SAMPLE, cnt_wall, cnt_idle, cnt_nice, cur);
  endtask

  task automatic send_start(input logic [WORD_W-1:0] wall, input logic [WORD_W-1:0] idle,
                            input logic [WORD_W-1:0] nice, input logic [FREQ_W-1:0] cur);
    cnt_wall = wall;
    cnt_idle = idle;
    cnt_nice = nice;
    send_item(OP_START, wall, idle, nice, cur);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every predicted result has come out.
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 7))
      0: return cfg_min;
      1: return cfg_max;
      2: return '0;
      3: return '1;
      default: begin
        if (cfg_min <= cfg_max) begin
          return FREQ_W'($urandom_range(cfg_min, cfg_max));
        end
        return FREQ_W'($urandom);
      end
    endcase
  endfunction

  task automatic random_item();
    logic [WORD_W-1:0] dwall;
    logic [WORD_W-1:0] didle;
    logic [WORD_W-1:0] dnice;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 72) begin
      case ($urandom_range(0, 9))
        0: dwall = '0;
        1: dwall = $urandom;
        default: dwall = $urandom_range(1, 20000);
      endcase
      // Idle time is mostly within the wall time, so the load spreads over 0 to 100.
      if ($urandom_range(0, 9) == 0) begin
        didle = dwall + $urandom_range(1, 5000);
      end else begin
        didle = $urandom_range(0, dwall);
      end
      case ($urandom_range(0, 7))
        0: dnice = $urandom;
        1, 2: dnice = $urandom_range(0, dwall >> 2);
        default: dnice = '0;
      endcase
      send_sample(dwall, didle, dnice, pick_freq());
    end else if (roll < 78) begin
      send_start($urandom, $urandom, $urandom, pick_freq());
    end else if (roll < 86) begin
      send_item(OP_NOTICE, $urandom, $urandom, $urandom, pick_freq());
    end else if (roll < 90) begin
      send_item(OP_UNUSED, $urandom, $urandom, $urandom, pick_freq());
    end else begin
      // A sample whose counters jump anywhere.
      cnt_wall = $urandom;
      cnt_idle = $urandom;
      cnt_nice = $urandom;
      send_item(OP_SAMPLE, cnt_wall, cnt_idle, cnt_nice, pick_freq());
    end
  endtask

  initial begin : stimulus
    int unsigned up;
    int unsigned down;
    int unsigned step;
    int unsigned lo;
    int unsigned hi;
    bit          ign;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default registers: a step is 260000 kHz, bounds 728000 to 2600000 kHz.
    send_sample(32'd1000, 32'd0, 32'd0, RST_MIN_FREQ);
    send_start(32'd10000, 32'd5000, 32'd0, 22'd1000000);
    send_sample(32'd1000, 32'd0, 32'd0, 22'd1000000);
    send_sample(32'd0, 32'd0, 32'd0, RST_MIN_FREQ);
    send_sample(32'd100, 32'd300, 32'd0, 22'd1000000);
    send_sample(32'd1000, 32'd500, 32'd0, 22'd1000000);
    send_sample(32'd1000, 32'd710, 32'd0, 22'd1000000);
    // Climb to the upper bound, then one more full-load sample while there.
    repeat (9) send_sample(32'd1000, 32'd0, 32'd0, 22'd2000000);
    send_item(OP_NOTICE, '1, '1, '1, 22'd123);
    send_item(OP_UNUSED, '1, '1, '1, '1);
    send_item(OP_SAMPLE, '1, '0, '1, '1);
    send_start('0, '1, '1, '1);
    send_item(OP_NOTICE, '0, '0, '0, 22'd500000);
    send_item(OP_NOTICE, '0, '0, '0, 22'd0);
    // Both counters wrap across these two samples.
    send_sample(32'hFFFF_FFF0, 32'd0, 32'd0, 22'd1);
    send_sample(32'h0000_0020, 32'd3, 32'd0, 22'd1);
    drain_requests();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          up = 11; down = 100; step = 100; ign = 1'b1; lo = 0; hi = 4194303;
        end
        1: begin
          up = 100; down = 11; step = 0; ign = 1'b0; lo = 4194303; hi = 0;
        end
        2: begin
          up = 50; down = 10; step = 127; ign = 1'b1; lo = 1000000; hi = 3000000;
        end
        3: begin
          up = 30; down = 60; step = 1; ign = 1'b0; lo = 0; hi = 99;
        end
        default: begin
          up = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(11, 100);
          down = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(11, 100);
          case ($urandom_range(0, 7))
            0: step = 0;
            1: step = $urandom_range(101, 127);
            2: step = $urandom_range(1, 3);
            default: step = $urandom_range(4, 100);
          endcase
          ign = $urandom_range(0, 1);
          case ($urandom_range(0, 5))
            0: begin
              hi = $urandom_range(0, 2000000);
              lo = $urandom_range(hi, 4194303);
            end
            1: begin
              lo = 0;
              hi = $urandom_range(0, 500);
            end
            default: begin
              lo = $urandom_range(0, 2000000);
              hi = $urandom_range(lo, 4194303);
            end
          endcase
        end
      endcase
      write_reg(REG_UP_THR, up);
      write_reg(REG_DOWN_THR, down);
      write_reg(REG_STEP_PCT, step);
      write_reg(REG_IGN_NICE, {31'd0, ign});
      write_reg(REG_MIN_FREQ, lo);
      write_reg(REG_MAX_FREQ, hi);
      cfg_min = FREQ_W'(lo);
      cfg_max = FREQ_W'(hi);

      send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      sink_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      no_idling = (phase == PHASES - 1);
      // The long hold-off makes the block fill up and push back on its input.
      long_stall = (phase == 2);
      repeat (PHASE_ITEMS) random_item();
      drain_requests();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
